@@ rtl/pstsu_pkg.sv @@
// Package with the types and codes shared by the packed sorted table search unit and its users.
package pstsu_pkg;

    // Operation carried by an input transaction.
    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    // Status carried by a result transaction.
    typedef enum logic [1:0] {
        ST_APPENDED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_REJECTED  = 2'd3
    } status_t;

    // Configuration register indexes; register i lies at byte address 4*i.
    typedef enum logic {
        REG_MAX_KEY   = 1'b0,
        REG_MAX_VALUE = 1'b1
    } reg_idx_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [31:0] MAX_RESET = 32'h0000_00FF;

    typedef struct packed {
        op_t         operation;
        logic [31:0] key;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] hit_key;
        logic [31:0] hit_value;
    } out_item_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_MID,
        S_READ,
        S_CMP,
        S_RESP
    } state_t;

endpackage

@@ rtl/packed_sorted_table_search_unit.sv @@
// Top level of the packed sorted table search unit: byte store, sequencer and APB registers.
//
// Usage. Input transactions arrive on s_valid/s_ready/s_item: an append adds one key/value
// pair after those already held, a lookup binary-searches the held pairs for a key. Every
// input transaction gives exactly one result transaction on m_valid/m_ready/m_item.
// Key and value widths follow from the maximum-key and maximum-value registers on the APB
// port; each pair occupies E = ceil((key bits + value bits) / 8) bytes of a single byte-wide
// synchronous memory with one write and one read port, and that port sets the timing.
// An append writes its E bytes in turn before its result; a rejected append or a trivially
// answered lookup goes straight to the result. Each lookup probe takes the steps address
// multiply, E reads pipelined through the registered read port, compare, with at most
// ceil(log2(n + 1)) probes for n held pairs; with 8-byte pairs over 4096 bytes that is at
// most 10 probes.
// One transaction is worked on at a time; s_ready is high whenever the sequencer is idle.
// The result sits in an output register, so a new transaction is accepted while an earlier
// result waits; if the receiver stalls, the next result is held in the sequencer until the
// output register is free, and no further transaction is accepted meanwhile.
// Reset (aresetn low at a clock edge) empties the table and sets both maximums to 255.
// Writing either register also empties the table. No clearing pass is needed: only bytes
// below the fill count are ever read.
module packed_sorted_table_search_unit #(
    parameter int TABLE_BYTES = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pstsu_pkg::in_item_t                 s_item,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output pstsu_pkg::out_item_t                m_item,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pstsu_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pstsu_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [pstsu_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);

    // Address width of the byte store, and width of the fill counters which must hold
    // TABLE_BYTES itself.
    localparam int AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
    localparam int CW = $clog2(TABLE_BYTES + 1);

    // Number of significant bits in a word, zero for zero.
    function automatic logic [5:0] bit_length(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

    // Mask of the low 'bits' bits of a 32-bit word.
    function automatic logic [31:0] width_mask(input logic [5:0] bits);
        logic [31:0] m;
        if (bits >= 6'd32) begin
            m = 32'hFFFF_FFFF;
        end else begin
            m = (32'd1 << bits) - 32'd1;
        end
        return m;
    endfunction

    // Configuration and the values derived from it, refreshed on every register write.
    logic [31:0]     max_key_reg;
    logic [31:0]     vmax_reg;
    logic [5:0]      kbits_reg;
    logic [5:0]      vbits_reg;
    logic [3:0]      ebytes_reg;
    logic [31:0]     kmask_reg;
    logic [31:0]     vmask_reg;

    // Table occupancy.
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   used_reg;

    // Sequencer and datapath.
    pstsu_pkg::state_t    state_reg;
    pstsu_pkg::state_t    state_next;
    logic [31:0]          key_reg;
    logic [63:0]          elem_reg;
    logic [AW-1:0]        wr_addr_reg;
    logic [3:0]           idx_reg;
    logic [CW-1:0]        lo_reg;
    logic [CW-1:0]        hi_reg;
    logic [CW-1:0]        mid_reg;
    logic [AW-1:0]        offset_reg;
    logic                 rvalid_reg;
    logic [2:0]           ridx_reg;
    logic [7:0]           rdata_reg;
    pstsu_pkg::out_item_t res_reg;
    pstsu_pkg::out_item_t m_item_reg;
    logic                 m_valid_reg;

    // The byte store itself; its contents are undefined until written.
    logic [7:0]           store_mem [TABLE_BYTES];

    // Combinational helpers.
    logic                 cfg_write;
    logic                 in_accept;
    logic                 key_fits;
    logic                 val_fits;
    logic                 room;
    logic                 append_ok;
    logic [63:0]          packed_elem;
    logic [CW:0]          mid_sum;
    logic [CW-1:0]        mid;
    logic [CW+3:0]        offset_prod;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [31:0]          elem_key;
    logic [31:0]          elem_value;
    logic                 hit;
    logic                 less;
    logic [CW-1:0]        lo_cmp;
    logic [CW-1:0]        hi_cmp;
    logic                 last_write;
    logic                 out_free;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == pstsu_pkg::REG_MAX_VALUE) ? vmax_reg : max_key_reg;

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // An append must fit both field widths and the remaining space of the store, and needs a non-zero element size.
    assign key_fits  = (s_item.key & ~kmask_reg) == 32'd0;
    assign val_fits  = (s_item.value & ~vmask_reg) == 32'd0;
    assign room      = ({1'b0, used_reg} + (CW+1)'(ebytes_reg)) <= (CW+1)'(TABLE_BYTES);
    assign append_ok = (ebytes_reg != 4'd0) && key_fits && val_fits && room;

    // The key sits in the low bits with the value directly above it.
    assign packed_elem = {32'd0, s_item.key} | ({32'd0, s_item.value} << kbits_reg);

    // Probe point and its byte offset; mid * E stays below the fill count.
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = mid_sum[CW:1];
    assign offset_prod = (CW+4)'(mid) * (CW+4)'(ebytes_reg);

    assign rd_addr     = offset_reg + AW'(idx_reg);

    // Key and value of the element gathered by the current probe.
    assign elem_key    = elem_reg[31:0] & kmask_reg;
    assign elem_value  = 32'(elem_reg >> kbits_reg) & vmask_reg;
    assign hit         = key_reg == elem_key;
    assign less        = key_reg < elem_key;
    assign lo_cmp      = less ? lo_reg : (mid_reg + CW'(1));
    assign hi_cmp      = less ? mid_reg : hi_reg;

    assign last_write  = idx_reg == (ebytes_reg - 4'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pstsu_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        rd_en      = 1'b0;
        case (state_reg)
            pstsu_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_item.operation == pstsu_pkg::OP_APPEND) begin
                        state_next = append_ok ? pstsu_pkg::S_WRITE : pstsu_pkg::S_RESP;
                    end else if (ebytes_reg != 4'd0 && count_reg != '0) begin
                        state_next = pstsu_pkg::S_MID;
                    end else begin
                        state_next = pstsu_pkg::S_RESP;
                    end
                end
            end
            pstsu_pkg::S_WRITE: begin
                if (last_write) begin
                    state_next = pstsu_pkg::S_RESP;
                end
            end
            pstsu_pkg::S_MID: begin
                state_next = pstsu_pkg::S_READ;
            end
            pstsu_pkg::S_READ: begin
                rd_en = idx_reg < ebytes_reg;
                if (idx_reg == ebytes_reg && rvalid_reg) begin
                    state_next = pstsu_pkg::S_CMP;
                end
            end
            pstsu_pkg::S_CMP: begin
                if (hit || !(lo_cmp < hi_cmp)) begin
                    state_next = pstsu_pkg::S_RESP;
                end else begin
                    state_next = pstsu_pkg::S_MID;
                end
            end
            pstsu_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = pstsu_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pstsu_pkg::S_IDLE;
            end
        endcase
    end

    // Byte store: one write port for appends, one registered read port for probes.
    always_ff @(posedge aclk) begin
        if (state_reg == pstsu_pkg::S_WRITE) begin
            store_mem[wr_addr_reg] <= elem_reg[7:0];
        end
        if (rd_en) begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    // Control registers that reset clears.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_key_reg   <= pstsu_pkg::MAX_RESET;
            vmax_reg      <= pstsu_pkg::MAX_RESET;
            kbits_reg     <= 6'd8;
            vbits_reg     <= 6'd8;
            ebytes_reg    <= 4'd2;
            kmask_reg     <= pstsu_pkg::MAX_RESET;
            vmask_reg     <= pstsu_pkg::MAX_RESET;
            count_reg     <= '0;
            used_reg      <= '0;
            rvalid_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rvalid_reg <= rd_en;
            // A new result replaces the old one only once that has gone or is going.
            if (state_reg == pstsu_pkg::S_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == pstsu_pkg::S_WRITE && last_write) begin
                used_reg  <= used_reg + CW'(ebytes_reg);
                count_reg <= count_reg + CW'(1);
            end
            if (cfg_write) begin
                // The element size depends on both widths, so either write refreshes it.
                if (paddr[2] == pstsu_pkg::REG_MAX_VALUE) begin
                    vmax_reg      <= pwdata;
                    vbits_reg     <= bit_length(pwdata);
                    vmask_reg     <= width_mask(bit_length(pwdata));
                    ebytes_reg    <= 4'((7'(kbits_reg) + 7'(bit_length(pwdata)) + 7'd7) >> 3);
                end else begin
                    max_key_reg   <= pwdata;
                    kbits_reg     <= bit_length(pwdata);
                    kmask_reg     <= width_mask(bit_length(pwdata));
                    ebytes_reg    <= 4'((7'(bit_length(pwdata)) + 7'(vbits_reg) + 7'd7) >> 3);
                end
                count_reg <= '0;
                used_reg  <= '0;
            end
        end
    end

    // Payload registers of the datapath.
    always_ff @(posedge aclk) begin
        ridx_reg <= idx_reg[2:0];
        if (rvalid_reg) begin
            elem_reg[8*ridx_reg +: 8] <= rdata_reg;
        end
        case (state_reg)
            pstsu_pkg::S_IDLE: begin
                if (in_accept) begin
                    key_reg     <= s_item.key;
                    elem_reg    <= packed_elem;
                    wr_addr_reg <= used_reg[AW-1:0];
                    idx_reg     <= 4'd0;
                    lo_reg      <= '0;
                    hi_reg      <= count_reg;
                    res_reg.hit_key   <= 32'd0;
                    res_reg.hit_value <= 32'd0;
                    if (s_item.operation == pstsu_pkg::OP_APPEND) begin
                        res_reg.status <= append_ok ? pstsu_pkg::ST_APPENDED
                                                    : pstsu_pkg::ST_REJECTED;
                    end else begin
                        res_reg.status <= pstsu_pkg::ST_NOT_FOUND;
                    end
                end
            end
            pstsu_pkg::S_WRITE: begin
                elem_reg    <= elem_reg >> 8;
                wr_addr_reg <= wr_addr_reg + AW'(1);
                idx_reg     <= idx_reg + 4'd1;
            end
            pstsu_pkg::S_MID: begin
                mid_reg    <= mid;
                offset_reg <= offset_prod[AW-1:0];
                idx_reg    <= 4'd0;
                elem_reg   <= 64'd0;
            end
            pstsu_pkg::S_READ: begin
                if (rd_en) begin
                    idx_reg <= idx_reg + 4'd1;
                end
            end
            pstsu_pkg::S_CMP: begin
                if (hit) begin
                    res_reg.status    <= pstsu_pkg::ST_FOUND;
                    res_reg.hit_key   <= elem_key;
                    res_reg.hit_value <= elem_value;
                end else begin
                    lo_reg <= lo_cmp;
                    hi_reg <= hi_cmp;
                end
            end
            pstsu_pkg::S_RESP: begin
                if (out_free) begin
                    m_item_reg <= res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // The fill count never passes the size of the store.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CW'(TABLE_BYTES))
        else $error("fill count beyond the store");

    // A probe only starts inside a non-empty window of held elements.
    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pstsu_pkg::S_MID |-> lo_reg < hi_reg && hi_reg <= count_reg)
        else $error("search window out of range");

    // Memory reads only happen with a non-zero element size.
    a_read_size: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> ebytes_reg != 4'd0)
        else $error("probe with zero element size");

    // Results other than a hit carry zero key and value.
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.status != pstsu_pkg::ST_FOUND
            |-> m_item_reg.hit_key == 32'd0 && m_item_reg.hit_value == 32'd0)
        else $error("non-zero fields on a result without a hit");

endmodule
